// ===== hdl/pbsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_pkg: shared types and constants for the P5 stream parser
// Character codes, result kinds and the result record handed between the
// parse stage and the output buffer.
// ----------------------------------------------------------------------------
package pbsp_pkg;

  localparam int DIM_BITS_DEF = 16;  // default width of the size registers
  localparam int FIELD_W      = 16;  // width of the width/height/max_gray fields
  localparam int KIND_W       = 2;

  localparam logic [7:0] CH_P     = 8'h50;  // 'P'
  localparam logic [7:0] CH_5     = 8'h35;  // '5'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [7:0]         pixel;
    logic               row_end;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
    logic [FIELD_W-1:0] max_gray;
  } result_t;

endpackage

// ===== hdl/pbsp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_parse: header state machine and pixel row counter
// Consumes one byte per step, updates the parse state and produces at most
// one result record for that byte.
// ----------------------------------------------------------------------------
module pbsp_parse #(
  parameter int DIM_BITS = pbsp_pkg::DIM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_q,
  output logic              emit,
  output pbsp_pkg::result_t res
);
  import pbsp_pkg::*;

  typedef enum logic [5:0] {
    PH_MAGIC  = 6'b000001,
    PH_WIDTH  = 6'b000010,
    PH_HEIGHT = 6'b000100,
    PH_GRAY   = 6'b001000,
    PH_IMAGE  = 6'b010000,
    PH_ERROR  = 6'b100000
  } phase_t;

  localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
  localparam logic [DIM_BITS-1:0] DIM_ONE = {{(DIM_BITS-1){1'b0}}, 1'b1};

  phase_t              phase, phase_next;
  logic [1:0]          magic_position, magic_position_next;
  logic                in_comment, in_comment_next;
  logic                comments_allowed, comments_allowed_next;
  logic [DIM_BITS-1:0] number_accumulator, number_accumulator_next;
  logic [DIM_BITS-1:0] width_reg, width_reg_next;
  logic [DIM_BITS-1:0] height_reg, height_reg_next;
  logic [DIM_BITS-1:0] gray_max_reg, gray_max_reg_next;
  logic [DIM_BITS-1:0] column_count, column_count_next;

  logic                is_eol, is_digit;
  logic [DIM_BITS+3:0] acc_sum;
  logic [DIM_BITS-1:0] acc_sat;
  logic [DIM_BITS-1:0] column_inc;
  logic [KIND_W-1:0]   kind;
  logic                row_end;
  logic [FIELD_W-1:0]  width_out, height_out, gray_out;

  assign is_eol   = byte_q inside {CH_LF, CH_CR};
  assign is_digit = byte_q inside {[CH_0:CH_9]};

  // acc * 10 + digit, clamp to the size register maximum
  assign acc_sum = {1'b0, number_accumulator, 3'b000}
                 + {3'b000, number_accumulator, 1'b0}
                 + {{DIM_BITS{1'b0}}, byte_q[3:0]};
  assign acc_sat = (acc_sum[DIM_BITS+3:DIM_BITS] != 4'd0) ? DIM_MAX
                                                          : acc_sum[DIM_BITS-1:0];
  assign column_inc = column_count + DIM_ONE;

  always_comb begin
    phase_next              = phase;
    magic_position_next     = magic_position;
    in_comment_next         = in_comment;
    comments_allowed_next   = comments_allowed;
    number_accumulator_next = number_accumulator;
    width_reg_next          = width_reg;
    height_reg_next         = height_reg;
    gray_max_reg_next       = gray_max_reg;
    column_count_next       = column_count;
    emit                    = 1'b0;
    kind                    = KIND_ERROR;
    row_end                 = 1'b0;

    if (step && phase != PH_ERROR) begin
      if (in_comment) begin
        if (is_eol) begin
          in_comment_next = 1'b0;
        end
      end else if (comments_allowed && byte_q == CH_HASH) begin
        in_comment_next = 1'b1;
      end else begin
        case (phase)
          PH_MAGIC: begin
            if (is_eol) begin
              if (magic_position != 2'd2) begin
                phase_next = PH_ERROR;
                emit       = 1'b1;
              end else begin
                phase_next              = PH_WIDTH;
                number_accumulator_next = '0;
              end
            end else if (magic_position == 2'd0 && byte_q == CH_P) begin
              magic_position_next = 2'd1;
            end else if (magic_position == 2'd1 && byte_q == CH_5) begin
              magic_position_next = 2'd2;
            end else begin
              phase_next = PH_ERROR;
              emit       = 1'b1;
            end
          end
          PH_WIDTH: begin
            comments_allowed_next = 1'b0;
            if (byte_q == CH_SPACE) begin
              if (number_accumulator == '0) begin
                phase_next = PH_ERROR;
                emit       = 1'b1;
              end else begin
                width_reg_next          = number_accumulator;
                number_accumulator_next = '0;
                phase_next              = PH_HEIGHT;
              end
            end else if (!is_digit) begin
              phase_next = PH_ERROR;
              emit       = 1'b1;
            end else begin
              number_accumulator_next = acc_sat;
            end
          end
          PH_HEIGHT, PH_GRAY: begin
            if (is_eol) begin
              number_accumulator_next = '0;
              if (phase == PH_HEIGHT) begin
                height_reg_next = number_accumulator;
                phase_next      = PH_GRAY;
              end else begin
                gray_max_reg_next = number_accumulator;
                column_count_next = '0;
                phase_next        = PH_IMAGE;
                emit              = 1'b1;
                kind              = KIND_HEADER;
              end
            end else if (!is_digit) begin
              phase_next = PH_ERROR;
              emit       = 1'b1;
            end else begin
              number_accumulator_next = acc_sat;
            end
          end
          PH_IMAGE: begin
            emit = 1'b1;
            kind = KIND_PIXEL;
            if (column_inc == width_reg) begin
              column_count_next = '0;
              row_end           = 1'b1;
            end else begin
              column_count_next = column_inc;
            end
          end
          default: begin
            phase_next = PH_ERROR;
          end
        endcase
      end
    end
  end

  // fit the size registers to the fixed result fields
  generate
    if (DIM_BITS >= FIELD_W) begin : g_trunc
      assign width_out  = width_reg_next[FIELD_W-1:0];
      assign height_out = height_reg_next[FIELD_W-1:0];
      assign gray_out   = gray_max_reg_next[FIELD_W-1:0];
    end else begin : g_ext
      assign width_out  = {{(FIELD_W-DIM_BITS){1'b0}}, width_reg_next};
      assign height_out = {{(FIELD_W-DIM_BITS){1'b0}}, height_reg_next};
      assign gray_out   = {{(FIELD_W-DIM_BITS){1'b0}}, gray_max_reg_next};
    end
  endgenerate

  always_comb begin
    res.kind     = kind;
    res.pixel    = (kind == KIND_PIXEL) ? byte_q : 8'd0;
    res.row_end  = row_end;
    res.width    = width_out;
    res.height   = height_out;
    res.max_gray = gray_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_MAGIC;
      magic_position     <= 2'd0;
      in_comment         <= 1'b0;
      comments_allowed   <= 1'b1;
      number_accumulator <= '0;
      width_reg          <= '0;
      height_reg         <= '0;
      gray_max_reg       <= '0;
      column_count       <= '0;
    end else begin
      phase              <= phase_next;
      magic_position     <= magic_position_next;
      in_comment         <= in_comment_next;
      comments_allowed   <= comments_allowed_next;
      number_accumulator <= number_accumulator_next;
      width_reg          <= width_reg_next;
      height_reg         <= height_reg_next;
      gray_max_reg       <= gray_max_reg_next;
      column_count       <= column_count_next;
    end
  end

endmodule

// ===== hdl/pbsp_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_out_buf: two-entry result buffer
// Head entry drives the output ports; the second entry absorbs a result
// produced while the head is stalled.
// ----------------------------------------------------------------------------
module pbsp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pbsp_pkg::result_t push_data,
  input  logic              stall,
  output logic              room,
  output logic              valid,
  output pbsp_pkg::result_t head
);
  import pbsp_pkg::*;

  logic [1:0] count;
  result_t    second;
  logic       pop;

  assign valid = (count != 2'd0);
  assign room  = (count != 2'd2);
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // advance the queue; the new result lands behind whatever remains
      if (count == 2'd1) begin
        head <= push_data;
      end else begin
        head   <= second;
        second <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        second <= push_data;
      end
    end
  end

endmodule

// ===== hdl/pgm_binary_stream_parser_core.sv =====
`timescale 1ns / 1ps
// Path: an accepted byte is captured in the input register; the parse logic then
//   writes its result into the result buffer, whose head drives the output ports.
// Throughput: one byte per cycle while the output is not stalled; the parse
//   state update is a single combinational step per byte.
// Reset: synchronous; clears the parse state to the magic phase and empties
//   both the input register and the result buffer.
// ----------------------------------------------------------------------------
// pgm_binary_stream_parser_core: binary PGM (P5) stream parser
// Checks the magic line, skips leading comments, reads width, height and gray
// maximum, emits a header result, then one per pixel byte; errors emit an error result.
// ----------------------------------------------------------------------------
module pgm_binary_stream_parser_core #(
  parameter int DIM_BITS = pbsp_pkg::DIM_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            byte_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [pbsp_pkg::KIND_W-1:0]           kind,
  output logic [7:0]                            pixel,
  output logic                                  row_end,
  output logic [pbsp_pkg::FIELD_W-1:0]          width,
  output logic [pbsp_pkg::FIELD_W-1:0]          height,
  output logic [pbsp_pkg::FIELD_W-1:0]          max_gray
);
  import pbsp_pkg::*;

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       room;
  logic       step;
  logic       emit;
  result_t    res;
  result_t    head;

  assign step     = byte_vld && room;
  assign in_stall = byte_vld && !room;

  // hold the byte until the buffer has room for its result
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (!in_stall) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= byte_in;
    end
  end

  pbsp_parse #(
    .DIM_BITS(DIM_BITS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .byte_q (byte_q),
    .emit   (emit),
    .res    (res)
  );

  pbsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (res),
    .stall     (out_stall),
    .room      (room),
    .valid     (out_valid),
    .head      (head)
  );

  assign kind     = head.kind;
  assign pixel    = head.pixel;
  assign row_end  = head.row_end;
  assign width    = head.width;
  assign height   = head.height;
  assign max_gray = head.max_gray;

endmodule

// ===== hdl/pbsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_checker: port-level checks for the P5 stream parser
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module pbsp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pbsp_pkg::KIND_W-1:0]  kind,
  input logic [7:0]                   pixel,
  input logic                         row_end
);
  import pbsp_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(pixel)
                               && $stable(row_end))
    else $error("stalled result changed");

  // an error transaction is the last one until reset
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && kind == KIND_ERROR |=> !out_valid)
    else $error("result after format error");

  a_non_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PIXEL |-> !row_end && pixel == 8'd0)
    else $error("header or error result carries pixel data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind pgm_binary_stream_parser_core pbsp_checker u_pbsp_checker (.*);
